// File: rtl/core/bls_pkg.sv
`timescale 1ns / 1ps

package bls_pkg;

    // Direction and axis flags of one classified segment.
    typedef struct packed {
        logic x_up;
        logic y_up;
        logic x_major;
    } seg_dir_t;

    // Status of the segment queue as seen by its producer and consumer.
    typedef struct packed {
        logic full;
        logic empty;
    } bls_q_status_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } bls_state_t;

    localparam int QUEUE_DEPTH = 2;

endpackage

// File: rtl/core/bls_seg_if.sv
`timescale 1ns / 1ps

interface bls_seg_if #(
    parameter int COORD_BITS = 6
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;

    modport source (
        output valid,
        output x_start,
        output y_start,
        output x_end,
        output y_end,
        input  ready
    );

    modport sink (
        input  valid,
        input  x_start,
        input  y_start,
        input  x_end,
        input  y_end,
        output ready
    );
endinterface

// File: rtl/core/bls_pix_if.sv
`timescale 1ns / 1ps

interface bls_pix_if #(
    parameter int COORD_BITS = 6
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  last;

    modport source (
        output valid,
        output pixel_x,
        output pixel_y,
        output last,
        input  ready
    );

    modport sink (
        input  valid,
        input  pixel_x,
        input  pixel_y,
        input  last,
        output ready
    );
endinterface

// File: rtl/core/bls_front.sv
`timescale 1ns / 1ps

module bls_front import bls_pkg::*; #(
    parameter int COORD_BITS = 6,
    parameter int DESC_W     = $bits(seg_dir_t) + 4 * COORD_BITS
) (
    bls_seg_if.sink               seg,
    input  bls_q_status_t         q_status,
    output logic                  push,
    output logic [DESC_W-1:0]     push_data
);

    seg_dir_t              dir;
    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic [COORD_BITS-1:0] major;
    logic [COORD_BITS-1:0] minor;
    logic                  empty_seg;

    always_comb
    begin
        dir.x_up    = (seg.x_end >= seg.x_start);
        dir.y_up    = (seg.y_end >= seg.y_start);
        dx          = dir.x_up ? (seg.x_end - seg.x_start) : (seg.x_start - seg.x_end);
        dy          = dir.y_up ? (seg.y_end - seg.y_start) : (seg.y_start - seg.y_end);
        dir.x_major = (dx >= dy);
        major       = dir.x_major ? dx : dy;
        minor       = dir.x_major ? dy : dx;
        empty_seg   = (dx == '0) && (dy == '0);
    end

    // A segment with identical endpoints is taken and dropped here.
    assign seg.ready = !q_status.full;
    assign push      = seg.valid && !q_status.full && !empty_seg;
    assign push_data = {dir, seg.x_start, seg.y_start, major, minor};

endmodule

// File: rtl/core/bls_queue.sv
`timescale 1ns / 1ps

module bls_queue import bls_pkg::*; #(
    parameter int DATA_W = 27,
    parameter int DEPTH  = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output bls_q_status_t     status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data     = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

// File: rtl/core/bls_back.sv
`timescale 1ns / 1ps

module bls_back import bls_pkg::*; #(
    parameter int COORD_BITS = 6,
    parameter int DESC_W     = $bits(seg_dir_t) + 4 * COORD_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  bls_q_status_t     q_status,
    output logic              pop,
    input  logic [DESC_W-1:0] pop_data,
    bls_pix_if.source         pix
);

    localparam int CB = COORD_BITS;

    bls_state_t    state_reg;
    bls_state_t    state_next;

    seg_dir_t      dir_in;
    logic [CB-1:0] x_in;
    logic [CB-1:0] y_in;
    logic [CB-1:0] major_in;
    logic [CB-1:0] minor_in;

    seg_dir_t      dir_reg;
    seg_dir_t      dir_next;
    logic [CB-1:0] x_reg;
    logic [CB-1:0] x_next;
    logic [CB-1:0] y_reg;
    logic [CB-1:0] y_next;
    logic [CB-1:0] major_reg;
    logic [CB-1:0] major_next;
    logic [CB-1:0] minor_reg;
    logic [CB-1:0] minor_next;
    logic [CB:0]   acc_reg;
    logic [CB:0]   acc_next;
    logic [CB-1:0] remain_reg;
    logic [CB-1:0] remain_next;

    logic          out_valid_reg;
    logic          out_valid_next;
    logic [CB-1:0] out_x_reg;
    logic [CB-1:0] out_x_next;
    logic [CB-1:0] out_y_reg;
    logic [CB-1:0] out_y_next;
    logic          out_last_reg;
    logic          out_last_next;

    logic          adv;
    logic          step;
    logic          last_step;
    logic [CB:0]   acc_sum;
    logic          minor_move;

    assign {dir_in, x_in, y_in, major_in, minor_in} = pop_data;

    assign adv       = !out_valid_reg || pix.ready;
    assign step      = (state_reg == ST_RUN) && adv;
    assign last_step = (remain_reg == CB'(1));
    assign pop       = (state_reg == ST_IDLE) && !q_status.empty;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (adv && last_step)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        acc_sum    = acc_reg + {1'b0, minor_reg};
        minor_move = (acc_sum >= {1'b0, major_reg});

        dir_next       = dir_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        major_next     = major_reg;
        minor_next     = minor_reg;
        acc_next       = acc_reg;
        remain_next    = remain_reg;
        out_valid_next = out_valid_reg && !pix.ready;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_last_next  = out_last_reg;

        if (pop)
        begin
            dir_next    = dir_in;
            x_next      = x_in;
            y_next      = y_in;
            major_next  = major_in;
            minor_next  = minor_in;
            acc_next    = {2'b00, major_in[CB-1:1]};
            remain_next = major_in;
        end
        else if (step)
        begin
            acc_next = minor_move ? (acc_sum - {1'b0, major_reg}) : acc_sum;
            if (dir_reg.x_major || minor_move)
            begin
                x_next = dir_reg.x_up ? (x_reg + CB'(1)) : (x_reg - CB'(1));
            end
            if (!dir_reg.x_major || minor_move)
            begin
                y_next = dir_reg.y_up ? (y_reg + CB'(1)) : (y_reg - CB'(1));
            end
            remain_next    = remain_reg - CB'(1);
            out_valid_next = 1'b1;
            out_x_next     = x_next;
            out_y_next     = y_next;
            out_last_next  = last_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dir_reg      <= dir_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        major_reg    <= major_next;
        minor_reg    <= minor_next;
        acc_reg      <= acc_next;
        remain_reg   <= remain_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_last_reg <= out_last_next;
    end

    assign pix.valid   = out_valid_reg;
    assign pix.pixel_x = out_x_reg;
    assign pix.pixel_y = out_y_reg;
    assign pix.last    = out_last_reg;

`ifndef NO_ASSERTIONS
    a_run_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> remain_reg != '0)
        else $error("Stepper is running with no pixels left.");

    a_acc_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> acc_reg < {1'b0, major_reg})
        else $error("Error accumulator has reached the major delta.");

    a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        step && last_step |=> state_reg == ST_IDLE && out_valid_reg && out_last_reg)
        else $error("Final pixel did not close the line.");
`endif

endmodule

// File: rtl/core/bresenham_line_stepper_unit.sv
`timescale 1ns / 1ps

// Draws one line segment per input beat and emits, one beat per pixel, every pixel after the
// start point up to and including the end point, with last set on the final pixel; a segment
// whose endpoints coincide is taken and gives no pixels. A front stage classifies each segment
// (deltas, step directions, major axis) and places it in a two-entry queue, so up to two more
// segments are taken while a line is being drawn. The back stage steps the error accumulator
// once per cycle while its output register is not stalled, emitting one pixel per step; it loads
// each segment from the queue in its idle state and takes the next only after the last pixel.
// Pixels leave through an output register, and a stall there holds the stepper.

module bresenham_line_stepper_unit import bls_pkg::*; #(
    parameter int COORD_BITS = 6
) (
    input  logic      clk,
    input  logic      rst_n,
    bls_seg_if.sink   seg,
    bls_pix_if.source pix
);

    localparam int DESC_W = $bits(seg_dir_t) + 4 * COORD_BITS;

    bls_q_status_t     q_status;
    logic              push;
    logic [DESC_W-1:0] push_data;
    logic              pop;
    logic [DESC_W-1:0] pop_data;

    bls_front #(
        .COORD_BITS (COORD_BITS),
        .DESC_W     (DESC_W)
    ) u_front (
        .seg       (seg),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    bls_queue #(
        .DATA_W (DESC_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    bls_back #(
        .COORD_BITS (COORD_BITS),
        .DESC_W     (DESC_W)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .pop      (pop),
        .pop_data (pop_data),
        .pix      (pix)
    );

endmodule
